// ===== design/tlpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpt_pkg: shared types and constants of the two-level page table engine
// Request codes, address split and entry layout of the directory and tables.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  typedef logic [1:0] func_t;

  localparam func_t FUNC_MAP    = 2'd0;
  localparam func_t FUNC_LOOKUP = 2'd1;
  localparam func_t FUNC_UNMAP  = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_SLOT = 1'b1;

  // virtual address split
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned DIR_ENTRIES = 1024;
  localparam int unsigned TBL_ENTRIES = 1024;
  localparam int unsigned DIR_SHIFT   = 22;
  localparam int unsigned TBL_SHIFT   = 12;

  // entry layout
  localparam int unsigned DIR_FLAG_W = 3;
  localparam int unsigned FLAG_W     = 12;
  localparam int unsigned FRAME_W    = 20;

  typedef logic [IDX_W-1:0] idx_t;

endpackage

// ===== design/two_level_page_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// two_level_page_table_engine_core: 32-bit two-level page table
// Directory of 1024 entries and a pool of TABLE_SLOTS page tables, each in
// a synchronous RAM; handles map, lookup and unmap requests.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one request: func_i
//   (map, lookup, unmap), virtual_address_i, physical_address_i and
//   entry_flags_i. Output channel (out_valid_o / out_ready_i) returns exactly
//   one result per request: found_o, frame_address_o and status_o.
//   Map, any request whose directory entry is absent and unused codes
//   finish in the directory stage; lookup and unmap that reach a present
//   directory entry go on to the table stage before their result is valid.
//   The directory RAM read is followed by the dependent page table RAM
//   read or write; one request is in flight at a time.
//   After reset a clearing pass zeroes both RAMs while in_ready_o stays low.
//   The result sits in an output register; a new request is taken while the
//   previous result is still held, as long as it is taken in the same cycle.
//   A stalled receiver therefore holds off all further requests.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_core
  import tlpt_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] virtual_address_i,
  input  logic [31:0] physical_address_i,
  input  logic [11:0] entry_flags_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [31:0] frame_address_o,
  output logic        status_o
);

  localparam int unsigned SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned DIR_W     = SLOT_W + DIR_FLAG_W;
  localparam int unsigned DIR_AW    = $clog2(DIR_ENTRIES);
  localparam int unsigned TBL_DEPTH = TABLE_SLOTS * TBL_ENTRIES;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);
  localparam int unsigned CNT_W     = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIR,
    ST_TBL
  } state_e;

  state_e              state_q;
  logic [TBL_AW-1:0]   clr_q;
  logic [CNT_W-1:0]    next_free_q;
  func_t               func_q;
  logic [31:0]         va_q;
  logic [31:0]         pa_q;
  logic [FLAG_W-1:0]   flags_q;
  logic [TBL_AW-1:0]   tbl_addr_q;
  logic                out_valid_q;
  logic                found_q;
  logic [31:0]         frame_q;
  logic                status_q;

  // memory ports
  logic                dir_we;
  logic [DIR_AW-1:0]   dir_addr;
  logic [DIR_W-1:0]    dir_wdata;
  logic [DIR_W-1:0]    dir_rdata;
  logic                tbl_we;
  logic [TBL_AW-1:0]   tbl_addr;
  logic [31:0]         tbl_wdata;
  logic [31:0]         tbl_rdata;

  // directory stage decode
  logic                accept;
  logic                dir_present;
  logic [SLOT_W-1:0]   dir_slot_raw;
  logic [SLOT_W-1:0]   dir_slot;
  logic [SLOT_W-1:0]   new_slot;
  logic [SLOT_W-1:0]   slot_sel;
  logic                have_slot;
  logic                map_ok;
  logic                clr_dir_en;
  idx_t                ti;
  logic [SLOT_W+IDX_W-1:0] slot_idx;

  assign accept      = in_valid_i & in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE) & (~out_valid_q | out_ready_i);

  assign dir_present  = dir_rdata[0];
  assign dir_slot_raw = dir_rdata[DIR_W-1:DIR_FLAG_W];
  // point an out-of-range slot number at slot zero
  assign dir_slot     = ({1'b0, dir_slot_raw} >= (SLOT_W+1)'(TABLE_SLOTS)) ?
                        '0 : dir_slot_raw;
  assign new_slot     = next_free_q[SLOT_W-1:0];
  assign have_slot    = next_free_q < CNT_W'(TABLE_SLOTS);
  assign map_ok       = dir_present | have_slot;
  assign slot_sel     = dir_present ? dir_slot : new_slot;
  assign ti           = va_q[TBL_SHIFT +: IDX_W];
  assign slot_idx     = {slot_sel, ti};
  assign clr_dir_en   = (clr_q >> DIR_AW) == '0;

  // Steer the two RAM ports: clearing pass, request address, table access.
  always_comb begin
    dir_we    = 1'b0;
    dir_addr  = virtual_address_i[DIR_SHIFT +: IDX_W];
    dir_wdata = {new_slot, flags_q[DIR_FLAG_W-1:0] | DIR_FLAG_W'(1)};
    tbl_we    = 1'b0;
    tbl_addr  = slot_idx[TBL_AW-1:0];
    tbl_wdata = {pa_q[31:TBL_SHIFT], flags_q};
    case (state_q)
      ST_CLEAR: begin
        dir_we    = clr_dir_en;
        dir_addr  = clr_q[DIR_AW-1:0];
        dir_wdata = '0;
        tbl_we    = 1'b1;
        tbl_addr  = clr_q;
        tbl_wdata = '0;
      end
      ST_DIR: begin
        dir_addr = va_q[DIR_SHIFT +: IDX_W];
        if (func_q == FUNC_MAP) begin
          // allocate a fresh slot when the directory entry is absent
          dir_we = ~dir_present & have_slot;
          tbl_we = map_ok;
        end
      end
      ST_TBL: begin
        tbl_addr  = tbl_addr_q;
        tbl_wdata = '0;
        // drop a present entry on unmap
        tbl_we    = (func_q == FUNC_UNMAP) & tbl_rdata[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      next_free_q <= '0;
      func_q      <= FUNC_MAP;
      va_q        <= '0;
      pa_q        <= '0;
      flags_q     <= '0;
      tbl_addr_q  <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      frame_q     <= '0;
      status_q    <= STATUS_OK;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == TBL_AW'(TBL_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            func_q  <= func_i;
            va_q    <= virtual_address_i;
            pa_q    <= physical_address_i;
            flags_q <= entry_flags_i;
            state_q <= ST_DIR;
          end
        end
        ST_DIR: begin
          found_q  <= 1'b0;
          frame_q  <= '0;
          status_q <= STATUS_OK;
          case (func_q)
            FUNC_MAP: begin
              if (!map_ok) begin
                status_q <= STATUS_NO_SLOT;
              end else if (!dir_present) begin
                next_free_q <= next_free_q + 1'b1;
              end
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end
            FUNC_LOOKUP, FUNC_UNMAP: begin
              if (dir_present) begin
                tbl_addr_q <= tbl_addr;
                state_q    <= ST_TBL;
              end else begin
                out_valid_q <= 1'b1;
                state_q     <= ST_IDLE;
              end
            end
            default: begin
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end
          endcase
        end
        ST_TBL: begin
          if (func_q == FUNC_LOOKUP && tbl_rdata[0]) begin
            found_q <= 1'b1;
            frame_q <= {tbl_rdata[31:TBL_SHIFT], {TBL_SHIFT{1'b0}}};
          end
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  tlpt_ram #(
    .WIDTH(DIR_W),
    .DEPTH(DIR_ENTRIES)
  ) u_dir_ram (
    .clk_i  (clk_i),
    .we_i   (dir_we),
    .addr_i (dir_addr),
    .wdata_i(dir_wdata),
    .rdata_o(dir_rdata)
  );

  tlpt_ram #(
    .WIDTH(32),
    .DEPTH(TBL_DEPTH)
  ) u_tbl_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .addr_i (tbl_addr),
    .wdata_i(tbl_wdata),
    .rdata_o(tbl_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign frame_address_o = frame_q;
  assign status_o        = status_q;

  // slot counter never passes the pool size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= CNT_W'(TABLE_SLOTS))
    else $error("slot counter beyond pool size");

  // a directory write outside the clearing pass hands out exactly one slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIR && dir_we) |=> next_free_q == CNT_W'($past(next_free_q) + 1'b1))
    else $error("directory allocation without slot advance");

  // an accepted request moves to the directory stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_DIR)
    else $error("accepted request not in directory stage");

  // a failed map never reports a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (!found_o && frame_address_o == '0))
    else $error("failed map with hit result");

  // table writes after the directory stage only ever clear an entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TBL && tbl_we) |-> tbl_wdata == '0)
    else $error("unmap writes non-zero entry");

endmodule

// ===== design/tlpt_ram.sv =====
// ----------------------------------------------------------------------------
// tlpt_ram: single-port synchronous RAM
// One access per cycle: write when we_i is high, else read into a registered
// output, which holds its value during a write.
// ----------------------------------------------------------------------------
module tlpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two-level page table engine
// Drives map, lookup, unmap and unused-code requests through the valid/ready input channel,
// walks a private copy of the directory and table pool for each accepted
// request, and compares every returned result field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import tlpt_pkg::*;

  localparam int unsigned POOL_SLOTS   = 16;
  localparam func_t       FUNC_UNUSED  = 2'd3;
  localparam int unsigned RANDOM_REQS  = 873;
  localparam int unsigned HOLD_AT_A    = 200;   // results seen before first long hold
  localparam int unsigned HOLD_AT_B    = 650;
  localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off, in cycles
  localparam int unsigned DRAIN_AT     = 450;   // request count at which sender drains
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TIME_LIMIT   = 12 * 600000;

  typedef struct packed {
    func_t       func;
    logic [31:0] vaddr;
    logic [31:0] paddr;
    logic [11:0] flags;
  } pt_req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] frame;
    logic        status;
  } pt_resp_t;

  // DUT ports; every input starts at a known value
  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        in_valid_i         = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i             = '0;
  logic [31:0] virtual_address_i  = '0;
  logic [31:0] physical_address_i = '0;
  logic [11:0] entry_flags_i      = '0;
  logic        out_valid_o;
  logic        out_ready_i        = 1'b0;
  logic        found_o;
  logic [31:0] frame_address_o;
  logic        status_o;

  two_level_page_table_engine_core #(
    .TABLE_SLOTS(POOL_SLOTS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .virtual_address_i  (virtual_address_i),
    .physical_address_i (physical_address_i),
    .entry_flags_i      (entry_flags_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .found_o            (found_o),
    .frame_address_o    (frame_address_o),
    .status_o           (status_o)
  );

  // --------------------------------------------------------------------------
  // Page table shadow: directory entries hold the slot number in bits 7..3
  // and the flags in bits 2..0 (bit 0 present); pool entries hold the frame
  // in 31..12 and the entry flags in 11..0 (bit 0 present).
  // --------------------------------------------------------------------------
  logic [7:0]  dir_shadow  [DIR_ENTRIES];
  logic [31:0] pool_shadow [POOL_SLOTS*TBL_ENTRIES];
  int unsigned slots_taken = 0;

  // coverage tallies for the closing summary
  int unsigned maps_done = 0, maps_refused = 0, hits = 0, misses = 0;
  int unsigned unmaps = 0, unused_codes = 0;

  pt_req_t     request_backlog[$];
  pt_resp_t    walk_results_q[$];
  pt_req_t     req_on_bus;
  int unsigned reqs_accepted = 0;
  int unsigned results_seen  = 0;
  int unsigned fail_cnt      = 0;
  int unsigned send_gap      = 0;
  int unsigned stall_left    = 0;
  idx_t        live_dir [POOL_SLOTS];

  initial begin
    for (int k = 0; k < DIR_ENTRIES; k++) dir_shadow[k] = '0;
    for (int k = 0; k < POOL_SLOTS*TBL_ENTRIES; k++) pool_shadow[k] = '0;
  end

  // Locate the table that a directory entry points to; fall back to slot 0
  // for a slot number beyond the pool.
  function automatic int unsigned slot_offset(input logic [7:0] dent);
    int unsigned slot;
    slot = dent[7:3];
    if (slot >= POOL_SLOTS) slot = 0;
    return slot * TBL_ENTRIES;
  endfunction

  // Apply one request to the shadow and return the result it must produce.
  function automatic pt_resp_t page_walk(input pt_req_t r);
    idx_t        di;
    idx_t        ti;
    int unsigned slot;
    int unsigned k;
    pt_resp_t    res;
    di  = r.vaddr[31:22];
    ti  = r.vaddr[21:12];
    res = '0;
    case (r.func)
      FUNC_MAP: begin
        if (!dir_shadow[di][0]) begin
          if (slots_taken >= POOL_SLOTS) begin
            res.status = STATUS_NO_SLOT;
          end else begin
            // take the next slot, clear it and hook it into the directory
            slot = slots_taken;
            slots_taken++;
            for (int e = 0; e < TBL_ENTRIES; e++) pool_shadow[slot*TBL_ENTRIES + e] = '0;
            dir_shadow[di] = {5'(slot), r.flags[2:0] | 3'b001};
          end
        end
        if (res.status == STATUS_OK) begin
          pool_shadow[slot_offset(dir_shadow[di]) + ti] = {r.paddr[31:12], r.flags};
          maps_done++;
        end else begin
          maps_refused++;
        end
      end
      FUNC_LOOKUP: begin
        if (dir_shadow[di][0] && pool_shadow[slot_offset(dir_shadow[di]) + ti][0]) begin
          res.found = 1'b1;
          res.frame = {pool_shadow[slot_offset(dir_shadow[di]) + ti][31:12], 12'h000};
          hits++;
        end else begin
          misses++;
        end
      end
      FUNC_UNMAP: begin
        unmaps++;
        if (dir_shadow[di][0]) begin
          k = slot_offset(dir_shadow[di]) + ti;
          if (pool_shadow[k][0]) pool_shadow[k] = '0;
        end
      end
      default: begin
        unused_codes++;
      end
    endcase
    return res;
  endfunction

  // Idle lengths: whole stretches without gaps, otherwise mostly short gaps
  // and now and then a long one.
  function automatic int unsigned pick_gap(input int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if ((n % 160) < 40) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_request(input func_t f, input logic [31:0] va,
                                        input logic [31:0] pa, input logic [11:0] fl);
    pt_req_t r;
    r.func  = f;
    r.vaddr = va;
    r.paddr = pa;
    r.flags = fl;
    request_backlog.push_back(r);
  endfunction

  function automatic idx_t hot_table_index();
    if ($urandom_range(0, 7) == 0) return idx_t'(TBL_ENTRIES - 1);
    return idx_t'($urandom_range(0, 6));
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Driver: take requests from the backlog, hold each until accepted, then
  // predict its result. Pause once at DRAIN_AT until every result is back.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pt_req_t nxt;
    logic    held;
    if (rst_ni) begin
      held = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        walk_results_q.push_back(page_walk(req_on_bus));
        reqs_accepted++;
        held     = 1'b0;
        send_gap = pick_gap(reqs_accepted);
      end
      if (!held) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (request_backlog.size() != 0 &&
                     !(reqs_accepted == DRAIN_AT && walk_results_q.size() != 0)) begin
          nxt                 = request_backlog.pop_front();
          req_on_bus          = nxt;
          held                = 1'b1;
          func_i             <= nxt.func;
          virtual_address_i  <= nxt.vaddr;
          physical_address_i <= nxt.paddr;
          entry_flags_i      <= nxt.flags;
        end
      end
      in_valid_i <= held;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each returned result against the oldest prediction, then
  // decide how long to hold off the next one.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pt_resp_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (walk_results_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_cnt++;
        end else begin
          want = walk_results_q.pop_front();
          if (found_o !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found_o);
            fail_cnt++;
          end
          if (frame_address_o !== want.frame) begin
            $error("frame_address: expected %08h, actual %08h", want.frame, frame_address_o);
            fail_cnt++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            fail_cnt++;
          end
        end
        results_seen++;
        // hold off for a long stretch twice so the engine backs up into its input
        if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) stall_left = LONG_HOLD;
        else stall_left = pick_gap(results_seen + 37);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ready_i <= (stall_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sel;
    func_t       f;
    logic [31:0] va;
    logic [11:0] fl;

    live_dir[0] = idx_t'(0);
    live_dir[1] = idx_t'(DIR_ENTRIES - 1);

    // empty table: miss, unmap of an absent directory entry, unused code
    queue_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 12'h000);
    queue_request(FUNC_UNMAP,  32'hFFFF_FFFF, 32'h0, 12'h000);
    queue_request(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    // first slot, all flags set, top frame
    queue_request(FUNC_MAP,    32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
    queue_request(FUNC_LOOKUP, 32'h0000_0FFF, 32'h0, 12'h000);
    // last directory entry, entry written without its present bit
    queue_request(FUNC_MAP,    32'hFFFF_F000, 32'h0000_0000, 12'h000);
    queue_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 12'h000);
    queue_request(FUNC_UNMAP,  32'hFFFF_F000, 32'h0, 12'h000);
    // directory already present: its flags stay, only the entry changes
    queue_request(FUNC_MAP,    32'h0000_1000, 32'h1234_5678, 12'h006);
    queue_request(FUNC_MAP,    32'h0000_1ABC, 32'h8000_0FFF, 12'h801);
    queue_request(FUNC_LOOKUP, 32'h0000_1000, 32'h0, 12'h000);
    queue_request(FUNC_UNMAP,  32'h0000_0000, 32'h0, 12'h000);
    queue_request(FUNC_LOOKUP, 32'h0000_0123, 32'h0, 12'h000);
    // use up the rest of the pool, then one map that finds no slot
    for (int d = 2; d < POOL_SLOTS; d++) begin
      live_dir[d] = idx_t'(d);
      queue_request(FUNC_MAP, {idx_t'(d), hot_table_index(), 12'($urandom)},
                    $urandom, 12'($urandom) | 12'h001);
    end
    queue_request(FUNC_MAP,    32'h8000_0000, 32'hA5A5_A5A5, 12'h007);

    // random traffic, mostly on the mapped directories and a handful of
    // table entries so that map, lookup and unmap keep meeting each other
    for (int n = 0; n < RANDOM_REQS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40)      f = FUNC_MAP;
      else if (sel < 75) f = FUNC_LOOKUP;
      else if (sel < 96) f = FUNC_UNMAP;
      else               f = FUNC_UNUSED;
      if ($urandom_range(0, 9) < 8)
        va = {live_dir[$urandom_range(0, POOL_SLOTS - 1)], hot_table_index(), 12'($urandom)};
      else
        va = $urandom;
      fl = 12'($urandom);
      if ($urandom_range(0, 3) != 0) fl[0] = 1'b1;
      queue_request(f, va, $urandom, fl);
    end

    while (request_backlog.size() != 0 || in_valid_i || walk_results_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run: %0d requests, %0d results; maps %0d done / %0d refused for want of a slot",
             reqs_accepted, results_seen, maps_done, maps_refused);
    $display("     lookups %0d hit / %0d missed, %0d unmaps, %0d unused codes, %0d slots used",
             hits, misses, unmaps, unused_codes, slots_taken);
    if (fail_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog: covers the clearing pass after reset and the slowest run
  initial begin
    #(TIME_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
design/tlpt_pkg.sv
design/tlpt_ram.sv
design/two_level_page_table_engine_core.sv
tb/sv/tb_top.sv
